@@ sv/gvn_pkg.sv @@
// shared types, constants and helpers for the grid vertex normal estimator
// no dependencies
`default_nettype none
package gvn_pkg;

  // geometry and storage
  localparam int MAX_COLS   = 32;
  localparam int COORD_BITS = 20;
  localparam int ROWS_W     = 12;
  localparam int NCOL_W     = 6;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CNT_W      = $clog2(MAX_COLS + 1);
  localparam int SLOT_W     = 2;
  localparam int DEPTH      = 3 * MAX_COLS;
  localparam int ADDR_W     = $clog2(DEPTH);

  // arithmetic widths
  localparam int DIFF_SHIFT = (COORD_BITS > 29) ? COORD_BITS - 29 : 0;
  localparam int DIFF_W     = COORD_BITS + 1 - DIFF_SHIFT;
  localparam int CROSS_W    = 2 * DIFF_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int MAG_B      = 30;
  localparam int SQ_W       = 64;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int ROOT_CW    = $clog2(ROOT_STEPS);
  localparam int LEN_W      = 32;
  localparam int FRAC_B     = 14;
  localparam int QUO_W      = FRAC_B + 1;
  localparam int QCNT_W     = $clog2(QUO_W);
  localparam int NUM_W      = MAG_B + FRAC_B + 1;
  localparam int NORM_W     = 16;
  localparam int ACC_W      = NORM_W + 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTWARD = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [NORM_W-1:0]     norm_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    vtx_t              data;
  } wr_t;

  // one row emission handed from front to back
  typedef struct packed {
    logic [ROWS_W-1:0] row;
    logic [SLOT_W-1:0] slot_cur;
    logic [SLOT_W-1:0] slot_prev;
    logic [SLOT_W-1:0] slot_next;
    logic              has_prev;
    logic              has_next;
    logic              last_run;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] slot_before(logic [SLOT_W-1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_after(logic [SLOT_W-1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(logic [SLOT_W-1:0] s,
                                                   logic [COL_W-1:0] c);
    return ADDR_W'(s) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // difference a - b, magnitude trimmed for very wide coordinates
  function automatic diff_t diff_of(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        m;
    diff_t                      r;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[COORD_BITS] ? -d : d;
    m = m >> DIFF_SHIFT;
    r = signed'(DIFF_W'(m));
    return d[COORD_BITS] ? -r : r;
  endfunction

endpackage
`default_nettype wire

@@ sv/gvn_unit.sv @@
// multi-cycle vector normalizer: shift, sum of squares, bitwise square root,
// restoring division per component; uses gvn_pkg
`default_nettype none
module gvn_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire gvn_pkg::cross_t vec [3],
  output gvn_pkg::norm_t       q [3],
  output logic                 zero,
  output logic                 done
);
  import gvn_pkg::*;

  typedef enum logic [6:0] {
    U_IDLE  = 7'b0000001,
    U_SHIFT = 7'b0000010,
    U_SQ    = 7'b0000100,
    U_ROOT0 = 7'b0001000,
    U_ROOT  = 7'b0010000,
    U_DIV0  = 7'b0100000,
    U_DIV   = 7'b1000000
  } ustate_t;

  ustate_t              state;
  logic [CROSS_W-1:0]   mag [3];
  logic [2:0]           neg;
  logic [1:0]           idx;
  logic [SQ_W-1:0]      sum;
  logic [SQ_W-1:0]      v;
  logic [SQ_W-1:0]      root;
  logic [SQ_W-1:0]      bitv;
  logic [ROOT_CW-1:0]   rcnt;
  logic                 first;
  logic [NUM_W-1:0]     rem;
  logic [NUM_W-1:0]     den;
  logic [QUO_W-1:0]     quo;
  logic [QCNT_W-1:0]    qcnt;

  logic                 too_big;
  logic [2*MAG_B-1:0]   sq;
  logic [SQ_W-1:0]      rt;
  logic [LEN_W-1:0]     len;
  logic                 ge;
  logic [QUO_W-1:0]     quo_next;
  norm_t                qv;

  always_comb begin
    too_big = (mag[0][CROSS_W-1:MAG_B] != '0) || (mag[1][CROSS_W-1:MAG_B] != '0) ||
              (mag[2][CROSS_W-1:MAG_B] != '0);
    sq       = mag[idx][MAG_B-1:0] * mag[idx][MAG_B-1:0];
    rt       = root + bitv;
    len      = root[LEN_W-1:0];
    ge       = (rem >= den);
    quo_next = {quo[QUO_W-2:0], ge};
    qv       = signed'(NORM_W'(quo_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vec[i][CROSS_W-1];
              mag[i] <= vec[i][CROSS_W-1] ? CROSS_W'(-vec[i]) : CROSS_W'(vec[i]);
            end
            state <= U_SHIFT;
          end
        end
        U_SHIFT: begin
          if (too_big) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            idx   <= 2'd0;
            sum   <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          sum <= sum + SQ_W'(sq);
          if (idx == 2'd2) begin
            state <= U_ROOT0;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        U_ROOT0: begin
          v     <= sum;
          root  <= '0;
          bitv  <= SQ_W'(1) << (SQ_W - 2);
          rcnt  <= '0;
          state <= U_ROOT;
        end
        U_ROOT: begin
          if (v >= rt) begin
            v    <= v - rt;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          rcnt <= rcnt + 1'b1;
          if (rcnt == ROOT_CW'(ROOT_STEPS - 1)) begin
            idx   <= 2'd0;
            first <= 1'b1;
            state <= U_DIV0;
          end
        end
        U_DIV0: begin
          if (first && len == '0) begin
            // zero length: zero vector, flagged
            for (int i = 0; i < 3; i++) q[i] <= '0;
            zero  <= 1'b1;
            done  <= 1'b1;
            state <= U_IDLE;
          end else begin
            first <= 1'b0;
            zero  <= 1'b0;
            rem   <= {1'b0, mag[idx][MAG_B-1:0], FRAC_B'(0)} + NUM_W'(len >> 1);
            den   <= NUM_W'(len) << FRAC_B;
            quo   <= '0;
            qcnt  <= '0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          if (ge) rem <= rem - den;
          den  <= den >> 1;
          quo  <= quo_next;
          qcnt <= qcnt + 1'b1;
          if (qcnt == QCNT_W'(QUO_W - 1)) begin
            q[idx] <= neg[idx] ? -qv : qv;
            if (idx == 2'd2) begin
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              idx   <= idx + 2'd1;
              state <= U_DIV0;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/gvn_front.sv @@
// front end: takes vertices, writes the row store, tracks row and column,
// issues row emission commands; uses gvn_pkg
`default_nettype none
module gvn_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire gvn_pkg::vtx_t             vtx,
  input  wire logic [gvn_pkg::ROWS_W-1:0] rows_eff,
  input  wire logic [gvn_pkg::CNT_W-1:0]  cols_eff,
  input  wire logic                      geo_clear,
  input  wire logic                      drained,
  input  wire logic                      q_full,
  output logic                           q_push,
  output gvn_pkg::cmd_t                  q_cmd,
  output gvn_pkg::wr_t                   wr
);
  import gvn_pkg::*;

  logic [ROWS_W-1:0] row_counter;
  logic [COL_W-1:0]  col_counter;
  logic [SLOT_W-1:0] slot;
  logic              pend_a;
  logic              pend_b;
  cmd_t              cmd_a;
  cmd_t              cmd_b;

  logic              take;
  logic              row_end;
  logic              frame_end;
  logic [CNT_W-1:0]  col_inc;

  always_comb begin
    in_ready  = !pend_a && !pend_b && drained;
    take      = in_valid && in_ready;
    col_inc   = CNT_W'(col_counter) + CNT_W'(1);
    row_end   = (col_inc >= cols_eff);
    frame_end = (row_counter >= rows_eff - ROWS_W'(1));
    wr.en     = take;
    wr.addr   = store_addr(slot, col_counter);
    wr.data   = vtx;
    q_push    = (pend_a || pend_b) && !q_full;
    q_cmd     = pend_a ? cmd_a : cmd_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
      slot        <= '0;
      pend_a      <= 1'b0;
      pend_b      <= 1'b0;
    end else if (geo_clear) begin
      row_counter <= '0;
      col_counter <= '0;
      slot        <= '0;
    end else begin
      if (q_push) begin
        if (pend_a) pend_a <= 1'b0;
        else pend_b <= 1'b0;
      end
      if (take) begin
        if (!row_end) begin
          col_counter <= col_counter + 1'b1;
        end else begin
          col_counter <= '0;
          // previous row is complete once this row's last column is in
          pend_a          <= (row_counter != '0);
          cmd_a.row       <= row_counter - ROWS_W'(1);
          cmd_a.slot_cur  <= slot_before(slot);
          cmd_a.slot_prev <= slot_before(slot_before(slot));
          cmd_a.slot_next <= slot;
          cmd_a.has_prev  <= (row_counter >= ROWS_W'(2));
          cmd_a.has_next  <= 1'b1;
          cmd_a.last_run  <= !frame_end;
          // final row of the frame
          pend_b          <= frame_end;
          cmd_b.row       <= row_counter;
          cmd_b.slot_cur  <= slot;
          cmd_b.slot_prev <= slot_before(slot);
          cmd_b.slot_next <= slot;
          cmd_b.has_prev  <= (row_counter != '0);
          cmd_b.has_next  <= 1'b0;
          cmd_b.last_run  <= 1'b1;
          if (frame_end) begin
            row_counter <= '0;
            slot        <= '0;
          end else begin
            row_counter <= row_counter + 1'b1;
            slot        <= slot_after(slot);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/gvn_queue.sv @@
// two-entry command queue between front and back; uses gvn_pkg
`default_nettype none
module gvn_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire gvn_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output gvn_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);
  import gvn_pkg::*;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_comb begin
    head  = slots[rptr];
    empty = (count == 2'd0);
    full  = (count == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

@@ sv/gvn_back.sv @@
// back end: row store, neighbor fetch, cross products, normalization and
// output register; uses gvn_pkg and gvn_unit
`default_nettype none
module gvn_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire gvn_pkg::wr_t              wr,
  input  wire logic                      q_valid,
  input  wire gvn_pkg::cmd_t             q_head,
  output logic                           q_pop,
  output logic                           busy,
  input  wire logic [gvn_pkg::CNT_W-1:0]  cols_eff,
  input  wire logic                      outward,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output gvn_pkg::norm_t                 norm_x,
  output gvn_pkg::norm_t                 norm_y,
  output gvn_pkg::norm_t                 norm_z,
  output logic [gvn_pkg::ROWS_W-1:0]     row_index,
  output logic [gvn_pkg::COL_W-1:0]      col_index,
  output logic                           degenerate,
  output logic                           last_of_run
);
  import gvn_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_RADDR = 7'b0000010,
    B_RDATA = 7'b0000100,
    B_CROSS = 7'b0001000,
    B_FACE  = 7'b0010000,
    B_NORM  = 7'b0100000,
    B_OUT   = 7'b1000000
  } bstate_t;

  vtx_t              mem [DEPTH];
  vtx_t              rd_data;
  logic [ADDR_W-1:0] rd_addr;

  bstate_t           state;
  cmd_t              cmd;
  logic [COL_W-1:0]  col;
  logic [2:0]        rsel;
  vtx_t              p;
  diff_t             d [4][3];
  logic [1:0]        face;
  logic [2:0]        mstep;
  cross_t            cx [3];
  logic signed [ACC_W-1:0] acc [3];
  cross_t            uvec [3];
  logic              ustart;
  norm_t             uq [3];
  logic              uzero;
  logic              udone;
  norm_t             res [3];
  logic              res_degen;

  logic [SLOT_W-1:0] rslot;
  logic [COL_W-1:0]  rcol;
  logic [COL_W-1:0]  col_n;
  logic [COL_W-1:0]  col_s;
  logic              col_last;
  logic [1:0]        fa;
  logic [1:0]        fb;
  diff_t             ma;
  diff_t             mb;
  logic signed [PROD_W-1:0] prod;
  diff_t             dnew [3];
  logic [1:0]        dsel;

  gvn_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (ustart),
    .vec   (uvec),
    .q     (uq),
    .zero  (uzero),
    .done  (udone)
  );

  // row store
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    col_last = (CNT_W'(col) == cols_eff - CNT_W'(1));
    col_n    = col_last ? COL_W'(1) : col + 1'b1;
    col_s    = (col == '0) ? COL_W'(cols_eff - CNT_W'(2)) : col - 1'b1;
    case (rsel)
      3'd1:    begin rslot = cmd.slot_cur;  rcol = col_n; end
      3'd2:    begin rslot = cmd.slot_cur;  rcol = col_s; end
      3'd3:    begin rslot = cmd.slot_prev; rcol = col;   end
      3'd4:    begin rslot = cmd.slot_next; rcol = col;   end
      default: begin rslot = cmd.slot_cur;  rcol = col;   end
    endcase
    rd_addr = store_addr(rslot, rcol);
    dsel    = 2'(rsel - 3'd1);
    dnew[0] = diff_of(rd_data.x, p.x);
    dnew[1] = diff_of(rd_data.y, p.y);
    dnew[2] = diff_of(rd_data.z, p.z);

    // diff slots: next col, prev col, prev row, next row
    case (face)
      2'd0:    begin fa = 2'd0; fb = 2'd2; end
      2'd1:    begin fa = 2'd2; fb = 2'd1; end
      2'd2:    begin fa = 2'd1; fb = 2'd3; end
      default: begin fa = 2'd3; fb = 2'd0; end
    endcase
    case (mstep)
      3'd0:    begin ma = d[fa][1]; mb = d[fb][2]; end
      3'd1:    begin ma = d[fa][2]; mb = d[fb][1]; end
      3'd2:    begin ma = d[fa][2]; mb = d[fb][0]; end
      3'd3:    begin ma = d[fa][0]; mb = d[fb][2]; end
      3'd4:    begin ma = d[fa][0]; mb = d[fb][1]; end
      default: begin ma = d[fa][1]; mb = d[fb][0]; end
    endcase
    prod  = ma * mb;
    q_pop = (state == B_IDLE) && q_valid;
    busy  = (state != B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      ustart    <= 1'b0;
    end else begin
      ustart <= 1'b0;
      // in B_OUT the output register is reloaded or held below
      if (out_valid && out_ready && state != B_OUT) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            cmd   <= q_head;
            col   <= '0;
            rsel  <= '0;
            state <= B_RADDR;
          end
        end
        B_RADDR: state <= B_RDATA;
        B_RDATA: begin
          if (rsel == 3'd0) begin
            p <= rd_data;
          end else begin
            d[dsel] <= dnew;
          end
          if (rsel == 3'd4) begin
            face  <= cmd.has_prev ? 2'd0 : 2'd2;
            mstep <= '0;
            for (int i = 0; i < 3; i++) acc[i] <= '0;
            state <= B_CROSS;
          end else begin
            rsel  <= rsel + 3'd1;
            state <= B_RADDR;
          end
        end
        B_CROSS: begin
          if (!mstep[0]) cx[mstep[2:1]] <= CROSS_W'(prod);
          else cx[mstep[2:1]] <= cx[mstep[2:1]] - CROSS_W'(prod);
          mstep <= mstep + 3'd1;
          if (mstep == 3'd5) begin
            state <= B_FACE;
            ustart <= 1'b1;
            uvec[0] <= cx[0];
            uvec[1] <= cx[1];
            uvec[2] <= cx[2] - CROSS_W'(prod);
          end
        end
        B_FACE: begin
          if (udone) begin
            for (int i = 0; i < 3; i++) acc[i] <= acc[i] + ACC_W'(uq[i]);
            mstep <= '0;
            if (face == 2'd0 || face == 2'd2) begin
              face  <= face + 2'd1;
              state <= B_CROSS;
            end else if (face == 2'd1 && cmd.has_next) begin
              face  <= 2'd2;
              state <= B_CROSS;
            end else begin
              for (int i = 0; i < 3; i++) uvec[i] <= CROSS_W'(acc[i] + ACC_W'(uq[i]));
              ustart <= 1'b1;
              state  <= B_NORM;
            end
          end
        end
        B_NORM: begin
          if (udone) begin
            for (int i = 0; i < 3; i++) res[i] <= outward ? -uq[i] : uq[i];
            res_degen <= uzero;
            state     <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            norm_x      <= res[0];
            norm_y      <= res[1];
            norm_z      <= res[2];
            row_index   <= cmd.row;
            col_index   <= col;
            degenerate  <= res_degen;
            last_of_run <= cmd.last_run && col_last;
            if (col_last) begin
              state <= B_IDLE;
            end else begin
              col   <= col + 1'b1;
              rsel  <= '0;
              state <= B_RADDR;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/grid_vertex_normal_estimator.sv @@
// top level of the grid vertex normal estimator: configuration registers,
// front end, command queue and back end; uses gvn_pkg and all gvn_ modules
`default_nettype none
// Vertices of a closed-seam grid arrive row-major, one per transfer, and are
// held in a three-row store. A vertex that does not end a row is accepted
// without holding off input. When the last column of a row is loaded, the
// block emits the normals of the row before it (and of this row too when it
// is the final row of the frame); input is held off until those normals are
// computed. A normal makes one pass of the shared normalize unit per face
// (four on an inner row, two on a first or last row) and one for the sum;
// each pass does operand shifts, a 32-step square root and three restoring
// divisions. The result sits in an output register, so the back end keeps
// going while the downstream side stalls for one result. Writing num_rows or
// num_cols restarts the frame; outward_facing applies from the next normal
// on.
module grid_vertex_normal_estimator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write_en,
  input  wire logic [gvn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gvn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [gvn_pkg::COORD_BITS-1:0] pos_x,
  input  wire logic [gvn_pkg::COORD_BITS-1:0] pos_y,
  input  wire logic [gvn_pkg::COORD_BITS-1:0] pos_z,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [gvn_pkg::NORM_W-1:0]          norm_x,
  output logic [gvn_pkg::NORM_W-1:0]          norm_y,
  output logic [gvn_pkg::NORM_W-1:0]          norm_z,
  output logic [gvn_pkg::ROWS_W-1:0]          row_index,
  output logic [gvn_pkg::COL_W-1:0]           col_index,
  output logic                                degenerate,
  output logic                                last_of_run
);
  import gvn_pkg::*;

  // configuration registers
  logic [ROWS_W-1:0] num_rows;
  logic [NCOL_W-1:0] num_cols;
  logic              outward_facing;

  logic [ROWS_W-1:0] rows_eff;
  logic [CNT_W-1:0]  cols_eff;
  logic [NCOL_W-1:0] cols_lo;
  logic              geo_clear;

  vtx_t  vtx;
  wr_t   wr;
  cmd_t  push_cmd;
  cmd_t  head;
  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;
  logic  back_busy;
  norm_t nx;
  norm_t ny;
  norm_t nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows       <= ROWS_W'(2);
      num_cols       <= NCOL_W'(3);
      outward_facing <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ROWS:    num_rows       <= cfg_data[ROWS_W-1:0];
        REG_COLS:    num_cols       <= cfg_data[NCOL_W-1:0];
        REG_OUTWARD: outward_facing <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    // geometry writes drop any partial frame
    geo_clear = cfg_write_en && (cfg_index == REG_ROWS || cfg_index == REG_COLS);
    // out-of-range geometry clamps to the nearest legal value
    rows_eff  = (num_rows < ROWS_W'(2)) ? ROWS_W'(2) : num_rows;
    cols_lo   = (num_cols < NCOL_W'(3)) ? NCOL_W'(3) : num_cols;
    cols_eff  = (CNT_W'(cols_lo) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(cols_lo);
    vtx.x     = pos_x;
    vtx.y     = pos_y;
    vtx.z     = pos_z;
    norm_x    = nx;
    norm_y    = ny;
    norm_z    = nz;
  end

  // front: vertex intake and row bookkeeping
  gvn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vtx       (vtx),
    .rows_eff  (rows_eff),
    .cols_eff  (cols_eff),
    .geo_clear (geo_clear),
    .drained   (q_empty && !back_busy),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd),
    .wr        (wr)
  );

  // row emission commands
  gvn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: normal computation and result transfer
  gvn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .q_valid     (!q_empty),
    .q_head      (head),
    .q_pop       (pop),
    .busy        (back_busy),
    .cols_eff    (cols_eff),
    .outward     (outward_facing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .norm_x      (nx),
    .norm_y      (ny),
    .norm_z      (nz),
    .row_index   (row_index),
    .col_index   (col_index),
    .degenerate  (degenerate),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

@@ tb/sv/grid_vertex_normal_estimator_tb.sv @@
// self-checking testbench for grid_vertex_normal_estimator
// depends on gvn_pkg and the block's RTL; drives vertex frames, checks normals
`timescale 1ns / 100ps
`default_nettype none
module grid_vertex_normal_estimator_tb;
  import gvn_pkg::*;

  // 64-bit vector used by the normal predictor
  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } v3_t;

  typedef struct packed {
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nz;
    logic [ROWS_W-1:0] row;
    logic [COL_W-1:0]  col;
    logic              degen;
    logic              last;
  } normal_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } vert_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_BITS-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [NORM_W-1:0] norm_x, norm_y, norm_z;
  logic [ROWS_W-1:0] row_index;
  logic [COL_W-1:0] col_index;
  logic degenerate, last_of_run;

  grid_vertex_normal_estimator u_dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .row_index(row_index), .col_index(col_index),
    .degenerate(degenerate), .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // vertices waiting to be sent, normals waiting to come out
  vert_t   vert_q[$];
  normal_t normal_q[$];
  int      n_fail = 0;
  int      n_sent = 0;
  logic    hold_req = 1'b0;

  // predictor copy of the block state and registers
  v3_t  grid_mem[3*MAX_COLS];
  int unsigned p_rows = 2, p_cols = 3, p_out = 0;
  int unsigned p_row = 0, p_col = 0;

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit vector in Q2.14; returns 1 on zero length
  function automatic bit unit_vec(input v3_t c, output v3_t q);
    longint unsigned m0, m1, m2, mx, sum, len;
    int s;
    m0 = mag(c.x);
    m1 = mag(c.y);
    m2 = mag(c.z);
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
    s = 0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    m0 = m0 >> s;
    m1 = m1 >> s;
    m2 = m2 >> s;
    sum = m0 * m0 + m1 * m1 + m2 * m2;
    len = isqrt(sum);
    q = '0;
    if (len == 0) return 1'b1;
    q.x = longint'((m0 * 16384 + len / 2) / len);
    q.y = longint'((m1 * 16384 + len / 2) / len);
    q.z = longint'((m2 * 16384 + len / 2) / len);
    if (c.x < 0) q.x = -q.x;
    if (c.y < 0) q.y = -q.y;
    if (c.z < 0) q.z = -q.z;
    return 1'b0;
  endfunction

  function automatic int unsigned eff_rows();
    return (p_rows < 2) ? 2 : p_rows;
  endfunction

  function automatic int unsigned eff_cols();
    int unsigned c;
    c = (p_cols < 3) ? 3 : p_cols;
    return (c > MAX_COLS) ? MAX_COLS : c;
  endfunction

  function automatic v3_t delta(int unsigned r, int unsigned c, v3_t p);
    v3_t d, v;
    v = grid_mem[(r % 3) * MAX_COLS + (c % MAX_COLS)];
    d.x = v.x - p.x;
    d.y = v.y - p.y;
    d.z = v.z - p.z;
    return d;
  endfunction

  // accumulate the unit face normal of a x b
  function automatic v3_t face_add(v3_t a, v3_t b, v3_t acc);
    v3_t c, q;
    c.x = a.y * b.z - a.z * b.y;
    c.y = a.z * b.x - a.x * b.z;
    c.z = a.x * b.y - a.y * b.x;
    void'(unit_vec(c, q));
    acc.x += q.x;
    acc.y += q.y;
    acc.z += q.z;
    return acc;
  endfunction

  function automatic void push_row_normals(int unsigned r);
    int unsigned nr, nc;
    v3_t p, n, s, w, e, acc, q;
    normal_t o;
    bit dg;
    nr = eff_rows();
    nc = eff_cols();
    for (int unsigned j = 0; j < nc; j++) begin
      p = grid_mem[(r % 3) * MAX_COLS + j];
      acc = '0;
      // column neighbours wrap across the closed seam
      n = delta(r, (j == nc - 1) ? 1 : j + 1, p);
      s = delta(r, (j == 0) ? nc - 2 : j - 1, p);
      if (r > 0) begin
        w = delta(r + 2, j, p);
        acc = face_add(n, w, acc);
        acc = face_add(w, s, acc);
      end
      if (r < nr - 1) begin
        e = delta(r + 1, j, p);
        acc = face_add(s, e, acc);
        acc = face_add(e, n, acc);
      end
      dg = unit_vec(acc, q);
      if (p_out != 0) begin
        q.x = -q.x;
        q.y = -q.y;
        q.z = -q.z;
      end
      o.nx = q.x[NORM_W-1:0];
      o.ny = q.y[NORM_W-1:0];
      o.nz = q.z[NORM_W-1:0];
      o.row = r[ROWS_W-1:0];
      o.col = j[COL_W-1:0];
      o.degen = dg;
      o.last = 1'b0;
      normal_q.push_back(o);
    end
  endfunction

  function automatic void load_vertex(vert_t v);
    v3_t p;
    int unsigned nr, nc, n_prior;
    nr = eff_rows();
    nc = eff_cols();
    p.x = longint'($signed(v.x));
    p.y = longint'($signed(v.y));
    p.z = longint'($signed(v.z));
    grid_mem[(p_row % 3) * MAX_COLS + (p_col % MAX_COLS)] = p;
    p_col++;
    if (p_col < nc) return;
    p_col = 0;
    n_prior = normal_q.size();
    if (p_row >= 1) push_row_normals(p_row - 1);
    if (p_row >= nr - 1) begin
      push_row_normals(p_row);
      p_row = 0;
    end else begin
      p_row++;
    end
    if (normal_q.size() > n_prior) normal_q[$].last = 1'b1;
  endfunction

  // driver: bursts of transfers with random gaps
  always @(posedge clk) begin : drv
    int gap, burst;
    logic nv;
    vert_t v;
    if (rst) begin
      in_valid <= 1'b0;
      gap = 0;
      burst = 1;
    end else begin
      if (in_valid && in_ready) begin
        v.x = pos_x;
        v.y = pos_y;
        v.z = pos_z;
        load_vertex(v);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        nv = 1'b0;
        if (gap > 0) begin
          gap--;
        end else if (vert_q.size() > 0) begin
          v = vert_q.pop_front();
          nv = 1'b1;
          pos_x <= v.x;
          pos_y <= v.y;
          pos_z <= v.z;
          burst--;
          if (burst <= 0) begin
            burst = $urandom_range(1, 20);
            // some bursts run back to back with no gap
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= nv;
      end
    end
  end

  // monitor: own stall pattern, one long hold-off on request
  always @(posedge clk) begin : mon
    int mode, mode_left, hold_left;
    logic hold_seen;
    normal_t e;
    if (rst) begin
      out_ready <= 1'b0;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      hold_seen = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (normal_q.size() == 0) begin
          $error("unexpected normal row %0d col %0d", row_index, col_index);
          n_fail++;
        end else begin
          e = normal_q.pop_front();
          if (norm_x !== e.nx) begin
            $error("norm_x exp %h got %h", e.nx, norm_x); n_fail++;
          end
          if (norm_y !== e.ny) begin
            $error("norm_y exp %h got %h", e.ny, norm_y); n_fail++;
          end
          if (norm_z !== e.nz) begin
            $error("norm_z exp %h got %h", e.nz, norm_z); n_fail++;
          end
          if (row_index !== e.row) begin
            $error("row_index exp %0d got %0d", e.row, row_index); n_fail++;
          end
          if (col_index !== e.col) begin
            $error("col_index exp %0d got %0d", e.col, col_index); n_fail++;
          end
          if (degenerate !== e.degen) begin
            $error("degenerate exp %0d got %0d", e.degen, degenerate); n_fail++;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run exp %0d got %0d", e.last, last_of_run); n_fail++;
          end
        end
      end
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 4000;
      end
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic cfg_wr(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_ROWS: begin
        p_rows = val & 12'hfff;
        p_row = 0;
        p_col = 0;
      end
      REG_COLS: begin
        p_cols = val & 6'h3f;
        p_row = 0;
        p_col = 0;
      end
      REG_OUTWARD: p_out = val & 1;
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // sender stays quiet until every queued normal is back
  task automatic drain();
    while (vert_q.size() > 0 || in_valid || normal_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] rnd_coord(int kind, int base);
    case (kind)
      0: return COORD_BITS'($urandom);
      1: return COORD_BITS'(base * 256 + $urandom_range(0, 64) - 32);
      default: return COORD_BITS'($urandom_range(0, 4) - 2);
    endcase
  endfunction

  // push a number of vertices laid out as a grid of nc columns
  task automatic add_verts(int count, int nc, int kind);
    vert_t v;
    for (int i = 0; i < count; i++) begin
      v.x = rnd_coord(kind, (i % nc) * 3);
      v.y = rnd_coord(kind, (i / nc) * 2);
      v.z = rnd_coord(kind, ((i % nc) * (i % nc)) % 7);
      vert_q.push_back(v);
    end
  endtask

  task automatic add_vert(int x, int y, int z);
    vert_t v;
    v.x = COORD_BITS'(x);
    v.y = COORD_BITS'(y);
    v.z = COORD_BITS'(z);
    vert_q.push_back(v);
  endtask

  localparam int CMAX = 524287;
  localparam int CMIN = -524288;

  initial begin : stim
    int nr, nc, kind, cnt, iter;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // flat grid of coincident points: every face is zero, sum degenerate
    cfg_wr(REG_ROWS, 2);
    cfg_wr(REG_COLS, 3);
    cfg_wr(REG_OUTWARD, 0);
    repeat (6) add_vert(0, 0, 0);
    // coordinate extremes, largest cross products
    add_vert(CMAX, CMIN, 0);
    add_vert(CMIN, CMAX, CMAX);
    add_vert(0, CMIN, CMIN);
    add_vert(CMIN, CMIN, CMAX);
    add_vert(CMAX, CMAX, CMIN);
    add_vert(CMAX, 0, CMIN);
    drain();
    // outward normals on the same extremes
    cfg_wr(REG_OUTWARD, 1);
    add_vert(CMIN, CMIN, CMIN);
    add_vert(CMAX, CMAX, CMAX);
    add_vert(CMAX, CMIN, CMAX);
    add_vert(0, 0, 1);
    add_vert(-1, 1, 0);
    add_vert(CMIN, 0, CMAX);
    drain();
    // out-of-range geometry clamps to 2 rows and 3 columns
    cfg_wr(REG_ROWS, 0);
    cfg_wr(REG_COLS, 1);
    add_verts(6, 3, 1);
    drain();

    // widest rows, tallest frame: one row out, the rest dropped by rewrite
    cfg_wr(REG_ROWS, 4095);
    cfg_wr(REG_COLS, 63);
    add_verts(64, 32, 1);
    drain();
    cfg_wr(REG_COLS, 32);
    cfg_wr(REG_ROWS, 2);
    add_verts(64, 32, 0);
    drain();

    iter = 0;
    while (n_sent < 470) begin
      nr = $urandom_range(2, 5);
      nc = $urandom_range(3, 8);
      if (iter == 2) begin
        // long receiver hold-off while the sender still has vertices to send
        nr = 4;
        nc = 4;
        hold_req <= 1'b1;
      end
      if ($urandom_range(0, 1)) cfg_wr(REG_ROWS, nr);
      else nr = eff_rows();
      if ($urandom_range(0, 1) || iter == 2) cfg_wr(REG_COLS, nc);
      else nc = eff_cols();
      if ($urandom_range(0, 2) == 0) cfg_wr(REG_OUTWARD, $urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      kind = (kind < 4) ? 0 : (kind < 8) ? 1 : 2;
      cnt = nr * nc * $urandom_range(1, 2);
      // occasionally a broken frame that stops partway
      if ($urandom_range(0, 7) == 0) cnt = $urandom_range(1, nr * nc);
      add_verts(cnt, nc, kind);
      drain();
      iter++;
    end

    drain();
    repeat (200) @(posedge clk);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
